@@ rtl/hid_active_key_tracker_core_defines.svh @@
// assertion macros used by the key tracker core
`ifndef HID_ACTIVE_KEY_TRACKER_CORE_DEFINES_SVH
`define HID_ACTIVE_KEY_TRACKER_CORE_DEFINES_SVH

// property that must hold at every edge outside reset
`define HAKT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// cause in this cycle, effect in the next one
`define HAKT_ASSERT_NEXT(lbl, cause, effect, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cause) |=> (effect)) \
    else $error(msg);

`endif

@@ rtl/hakt_pkg.sv @@
// shared types and constants of the key tracker
`default_nettype none

package hakt_pkg;

  localparam int unsigned MAX_KEYS_DEF = 6;
  localparam logic [7:0]  EMPTY_CODE   = 8'hFF;

  typedef struct packed {
    logic [7:0] key_code;
    logic       key_is_modifier;
    logic       key_down;
  } key_t;

  typedef struct packed {
    logic       record_kind;
    logic [2:0] slot_index;
    logic [7:0] slot_keycode;
    logic       slot_modifier;
    logic       slot_pressed;
    logic [2:0] active_keys;
    logic       last_record;
  } result_t;

  typedef struct packed {
    logic [7:0] keycode;
    logic       modifier;
    logic       pressed;
  } slot_t;

  localparam slot_t SLOT_EMPTY = '{keycode: EMPTY_CODE, modifier: 1'b0, pressed: 1'b0};

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_REMOVE,
    CELL_APPEND,
    CELL_ROTATE
  } cell_op_e;

  // key looked up in every cell and loaded on a press
  typedef struct packed {
    logic [7:0] key_code;
    logic       modifier;
  } cell_key_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_REPORT,
    ST_NOTICE
  } state_e;

  localparam logic KIND_SLOT   = 1'b0;
  localparam logic KIND_NOTICE = 1'b1;

endpackage

`default_nettype wire

@@ rtl/hid_active_key_tracker_core.sv @@
// top level of the held key tracker: control, count and the row of slot cells
//
// Keeps the keys currently held, in press order, in a row of MAX_KEYS slot
// cells. A beat is taken when start is high and busy is low; busy then stays
// high until every result of that beat has gone out. The first cycle after
// the beat looks the key up in all cells at once and applies the release
// (the cells from the hit onward take their right neighbor) or the press
// (the first free cell loads the key). When the table changed, results follow
// at once: with reporting enabled, one slot record per cycle, MAX_KEYS in
// all, read from cell 0 while the row rotates one place a cycle and ends
// where it began; with reporting disabled, a single notice. When nothing
// changed, the beat ends with no result. Results are shown for exactly one
// cycle with result_valid_o high and the receiver cannot stall them. The
// register report_enable is written through cfg_we_i / cfg_wdata_i and
// should change only while busy is low.
`default_nettype none
`include "hid_active_key_tracker_core_defines.svh"

module hid_active_key_tracker_core #(
  parameter int unsigned MAX_KEYS = hakt_pkg::MAX_KEYS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output      logic             busy,
  input  wire hakt_pkg::key_t   key_i,
  output      logic             result_valid_o,
  output      hakt_pkg::result_t result_o,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_wdata_i
);
  import hakt_pkg::*;

  // wide enough for a count of MAX_KEYS
  localparam int unsigned CW = $clog2(MAX_KEYS + 1);

  state_e        state_q, state_d;
  key_t          key_q;
  logic          report_en_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  cell_op_e      cell_op;
  cell_key_t     cell_key;
  slot_t         slots [MAX_KEYS];
  slot_t         nbr   [MAX_KEYS];
  logic [MAX_KEYS:0] hit;
  logic          found, full, last_idx;
  logic [CW+2:0] idx_ext, count_ext;

  // key of the held beat, compared in every cell
  assign cell_key = '{key_code: key_q.key_code, modifier: key_q.key_is_modifier};

  // row of cells, hit flag ripples left to right
  assign hit[0] = 1'b0;

  for (genvar g = 0; g < MAX_KEYS; g++) begin : g_cell
    if (g == MAX_KEYS - 1) begin : g_tail
      // tail wraps to the head while reporting, refills empty on a removal
      assign nbr[g] = (state_q == ST_REPORT) ? slots[0] : SLOT_EMPTY;
    end else begin : g_body
      assign nbr[g] = slots[g+1];
    end

    hakt_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (cell_op),
      .key_i   (cell_key),
      .count_i (count_q),
      .nbr_i   (nbr[g]),
      .hit_i   (hit[g]),
      .hit_o   (hit[g+1]),
      .slot_o  (slots[g])
    );
  end

  assign found    = hit[MAX_KEYS];
  assign full     = (count_q == CW'(MAX_KEYS));
  assign last_idx = (idx_q == CW'(MAX_KEYS - 1));
  assign busy     = (state_q != ST_IDLE);

  // fields are three bits wide whatever the table size
  assign idx_ext   = {3'b000, idx_q};
  assign count_ext = {3'b000, count_q};

  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    idx_d          = idx_q;
    cell_op        = CELL_HOLD;
    result_valid_o = 1'b0;
    result_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        idx_d   = '0;
        state_d = ST_IDLE;
        if (found && !key_q.key_down) begin
          cell_op = CELL_REMOVE;
          count_d = count_q - CW'(1);
          state_d = report_en_q ? ST_REPORT : ST_NOTICE;
        end else if (!found && key_q.key_down && !full) begin
          cell_op = CELL_APPEND;
          count_d = count_q + CW'(1);
          state_d = report_en_q ? ST_REPORT : ST_NOTICE;
        end
      end
      ST_REPORT: begin
        cell_op                = CELL_ROTATE;
        result_valid_o         = 1'b1;
        result_o.record_kind   = KIND_SLOT;
        result_o.slot_index    = idx_ext[2:0];
        result_o.slot_keycode  = slots[0].keycode;
        result_o.slot_modifier = slots[0].modifier;
        result_o.slot_pressed  = slots[0].pressed;
        result_o.active_keys   = count_ext[2:0];
        result_o.last_record   = last_idx;
        idx_d                  = idx_q + CW'(1);
        if (last_idx) begin
          state_d = ST_IDLE;
        end
      end
      ST_NOTICE: begin
        result_valid_o       = 1'b1;
        result_o.record_kind = KIND_NOTICE;
        result_o.active_keys = count_ext[2:0];
        result_o.last_record = 1'b1;
        state_d              = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      report_en_q <= 1'b1;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      if (cfg_we_i) begin
        report_en_q <= cfg_wdata_i;
      end
    end
  end

  // event beat, held for the lookup cycle
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      key_q <= key_i;
    end
  end

  // checks
  `HAKT_ASSERT(a_count_range, count_q <= CW'(MAX_KEYS), "held count above table size")
  `HAKT_ASSERT(a_result_busy, !result_valid_o || busy, "result shown while idle")
  `HAKT_ASSERT_NEXT(a_last_ends, result_valid_o && result_o.last_record, !busy,
                    "still busy after last record")
  `HAKT_ASSERT_NEXT(a_beat_lookup, start && !busy, busy && !result_valid_o,
                    "accepted beat did not enter lookup")

endmodule

`default_nettype wire

@@ rtl/hakt_cell.sv @@
// one slot of the held key table
`default_nettype none

module hakt_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 3
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire hakt_pkg::cell_op_e  op_i,
  input  wire hakt_pkg::cell_key_t key_i,
  input  wire logic [CW-1:0]       count_i,
  input  wire hakt_pkg::slot_t     nbr_i,
  input  wire logic                hit_i,
  output      logic                hit_o,
  output      hakt_pkg::slot_t     slot_o
);
  import hakt_pkg::*;

  slot_t slot_q, slot_d;
  logic  match;

  assign match  = slot_q.pressed && (slot_q.keycode == key_i.key_code)
                  && (slot_q.modifier == key_i.modifier);
  assign hit_o  = hit_i | match;
  assign slot_o = slot_q;

  always_comb begin
    slot_d = slot_q;
    case (op_i)
      CELL_REMOVE: begin
        // the removed entry and every entry after it take their successor
        if (hit_o) begin
          slot_d = nbr_i;
        end
      end
      CELL_APPEND: begin
        if (count_i == CW'(IDX)) begin
          slot_d = '{keycode: key_i.key_code, modifier: key_i.modifier, pressed: 1'b1};
        end
      end
      CELL_ROTATE: slot_d = nbr_i;
      default:     slot_d = slot_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= SLOT_EMPTY;
    end else begin
      slot_q <= slot_d;
    end
  end

endmodule

`default_nettype wire
